// ===== hdl/des_pkg.sv =====
// Shared types, permutation tables and bit-mapping functions for the DES core.
package des_pkg;

  localparam int ROUND_COUNT_DEF = 16;
  localparam int BLOCK_W = 64;
  localparam int HALF_W = 32;
  localparam int RKEY_W = 48;
  localparam int KHALF_W = 28;

  typedef logic [RKEY_W-1:0] rkey_t;

  // Payload of one pipeline stage; the valid bit travels beside it.
  typedef struct packed {
    logic              mode;
    logic [HALF_W-1:0] l;
    logic [HALF_W-1:0] r;
  } des_stage_t;

  localparam logic [6:0] IP_TAB [0:63] = '{
    7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18, 7'd10, 7'd2,
    7'd60, 7'd52, 7'd44, 7'd36, 7'd28, 7'd20, 7'd12, 7'd4,
    7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22, 7'd14, 7'd6,
    7'd64, 7'd56, 7'd48, 7'd40, 7'd32, 7'd24, 7'd16, 7'd8,
    7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,
    7'd59, 7'd51, 7'd43, 7'd35, 7'd27, 7'd19, 7'd11, 7'd3,
    7'd61, 7'd53, 7'd45, 7'd37, 7'd29, 7'd21, 7'd13, 7'd5,
    7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15, 7'd7};

  localparam logic [6:0] FP_TAB [0:63] = '{
    7'd40, 7'd8, 7'd48, 7'd16, 7'd56, 7'd24, 7'd64, 7'd32,
    7'd39, 7'd7, 7'd47, 7'd15, 7'd55, 7'd23, 7'd63, 7'd31,
    7'd38, 7'd6, 7'd46, 7'd14, 7'd54, 7'd22, 7'd62, 7'd30,
    7'd37, 7'd5, 7'd45, 7'd13, 7'd53, 7'd21, 7'd61, 7'd29,
    7'd36, 7'd4, 7'd44, 7'd12, 7'd52, 7'd20, 7'd60, 7'd28,
    7'd35, 7'd3, 7'd43, 7'd11, 7'd51, 7'd19, 7'd59, 7'd27,
    7'd34, 7'd2, 7'd42, 7'd10, 7'd50, 7'd18, 7'd58, 7'd26,
    7'd33, 7'd1, 7'd41, 7'd9,  7'd49, 7'd17, 7'd57, 7'd25};

  localparam logic [5:0] EXP_TAB [0:47] = '{
    6'd32, 6'd1,  6'd2,  6'd3,  6'd4,  6'd5,
    6'd4,  6'd5,  6'd6,  6'd7,  6'd8,  6'd9,
    6'd8,  6'd9,  6'd10, 6'd11, 6'd12, 6'd13,
    6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17,
    6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21,
    6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25,
    6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29,
    6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd1};

  localparam logic [5:0] PERM_TAB [0:31] = '{
    6'd16, 6'd7,  6'd20, 6'd21, 6'd29, 6'd12, 6'd28, 6'd17,
    6'd1,  6'd15, 6'd23, 6'd26, 6'd5,  6'd18, 6'd31, 6'd10,
    6'd2,  6'd8,  6'd24, 6'd14, 6'd32, 6'd27, 6'd3,  6'd9,
    6'd19, 6'd13, 6'd30, 6'd6,  6'd22, 6'd11, 6'd4,  6'd25};

  localparam logic [6:0] PC1_TAB [0:55] = '{
    7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,
    7'd1,  7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18,
    7'd10, 7'd2,  7'd59, 7'd51, 7'd43, 7'd35, 7'd27,
    7'd19, 7'd11, 7'd3,  7'd60, 7'd52, 7'd44, 7'd36,
    7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15,
    7'd7,  7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22,
    7'd14, 7'd6,  7'd61, 7'd53, 7'd45, 7'd37, 7'd29,
    7'd21, 7'd13, 7'd5,  7'd28, 7'd20, 7'd12, 7'd4};

  localparam logic [5:0] PC2_TAB [0:47] = '{
    6'd14, 6'd17, 6'd11, 6'd24, 6'd1,  6'd5,
    6'd3,  6'd28, 6'd15, 6'd6,  6'd21, 6'd10,
    6'd23, 6'd19, 6'd12, 6'd4,  6'd26, 6'd8,
    6'd16, 6'd7,  6'd27, 6'd20, 6'd13, 6'd2,
    6'd41, 6'd52, 6'd31, 6'd37, 6'd47, 6'd55,
    6'd30, 6'd40, 6'd51, 6'd45, 6'd33, 6'd48,
    6'd44, 6'd49, 6'd39, 6'd56, 6'd34, 6'd53,
    6'd46, 6'd42, 6'd50, 6'd36, 6'd29, 6'd32};

  localparam logic [1:0] ROT_TAB [0:15] = '{
    2'd1, 2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2,
    2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd1};

  localparam logic [3:0] SBOX_TAB [0:7][0:3][0:15] = '{
    '{'{4'd14, 4'd4, 4'd13, 4'd1, 4'd2, 4'd15, 4'd11, 4'd8,
        4'd3, 4'd10, 4'd6, 4'd12, 4'd5, 4'd9, 4'd0, 4'd7},
      '{4'd0, 4'd15, 4'd7, 4'd4, 4'd14, 4'd2, 4'd13, 4'd1,
        4'd10, 4'd6, 4'd12, 4'd11, 4'd9, 4'd5, 4'd3, 4'd8},
      '{4'd4, 4'd1, 4'd14, 4'd8, 4'd13, 4'd6, 4'd2, 4'd11,
        4'd15, 4'd12, 4'd9, 4'd7, 4'd3, 4'd10, 4'd5, 4'd0},
      '{4'd15, 4'd12, 4'd8, 4'd2, 4'd4, 4'd9, 4'd1, 4'd7,
        4'd5, 4'd11, 4'd3, 4'd14, 4'd10, 4'd0, 4'd6, 4'd13}},
    '{'{4'd15, 4'd1, 4'd8, 4'd14, 4'd6, 4'd11, 4'd3, 4'd4,
        4'd9, 4'd7, 4'd2, 4'd13, 4'd12, 4'd0, 4'd5, 4'd10},
      '{4'd3, 4'd13, 4'd4, 4'd7, 4'd15, 4'd2, 4'd8, 4'd14,
        4'd12, 4'd0, 4'd1, 4'd10, 4'd6, 4'd9, 4'd11, 4'd5},
      '{4'd0, 4'd14, 4'd7, 4'd11, 4'd10, 4'd4, 4'd13, 4'd1,
        4'd5, 4'd8, 4'd12, 4'd6, 4'd9, 4'd3, 4'd2, 4'd15},
      '{4'd13, 4'd8, 4'd10, 4'd1, 4'd3, 4'd15, 4'd4, 4'd2,
        4'd11, 4'd6, 4'd7, 4'd12, 4'd0, 4'd5, 4'd14, 4'd9}},
    '{'{4'd10, 4'd0, 4'd9, 4'd14, 4'd6, 4'd3, 4'd15, 4'd5,
        4'd1, 4'd13, 4'd12, 4'd7, 4'd11, 4'd4, 4'd2, 4'd8},
      '{4'd13, 4'd7, 4'd0, 4'd9, 4'd3, 4'd4, 4'd6, 4'd10,
        4'd2, 4'd8, 4'd5, 4'd14, 4'd12, 4'd11, 4'd15, 4'd1},
      '{4'd13, 4'd6, 4'd4, 4'd9, 4'd8, 4'd15, 4'd3, 4'd0,
        4'd11, 4'd1, 4'd2, 4'd12, 4'd5, 4'd10, 4'd14, 4'd7},
      '{4'd1, 4'd10, 4'd13, 4'd0, 4'd6, 4'd9, 4'd8, 4'd7,
        4'd4, 4'd15, 4'd14, 4'd3, 4'd11, 4'd5, 4'd2, 4'd12}},
    '{'{4'd7, 4'd13, 4'd14, 4'd3, 4'd0, 4'd6, 4'd9, 4'd10,
        4'd1, 4'd2, 4'd8, 4'd5, 4'd11, 4'd12, 4'd4, 4'd15},
      '{4'd13, 4'd8, 4'd11, 4'd5, 4'd6, 4'd15, 4'd0, 4'd3,
        4'd4, 4'd7, 4'd2, 4'd12, 4'd1, 4'd10, 4'd14, 4'd9},
      '{4'd10, 4'd6, 4'd9, 4'd0, 4'd12, 4'd11, 4'd7, 4'd13,
        4'd15, 4'd1, 4'd3, 4'd14, 4'd5, 4'd2, 4'd8, 4'd4},
      '{4'd3, 4'd15, 4'd0, 4'd6, 4'd10, 4'd1, 4'd13, 4'd8,
        4'd9, 4'd4, 4'd5, 4'd11, 4'd12, 4'd7, 4'd2, 4'd14}},
    '{'{4'd2, 4'd12, 4'd4, 4'd1, 4'd7, 4'd10, 4'd11, 4'd6,
        4'd8, 4'd5, 4'd3, 4'd15, 4'd13, 4'd0, 4'd14, 4'd9},
      '{4'd14, 4'd11, 4'd2, 4'd12, 4'd4, 4'd7, 4'd13, 4'd1,
        4'd5, 4'd0, 4'd15, 4'd10, 4'd3, 4'd9, 4'd8, 4'd6},
      '{4'd4, 4'd2, 4'd1, 4'd11, 4'd10, 4'd13, 4'd7, 4'd8,
        4'd15, 4'd9, 4'd12, 4'd5, 4'd6, 4'd3, 4'd0, 4'd14},
      '{4'd11, 4'd8, 4'd12, 4'd7, 4'd1, 4'd14, 4'd2, 4'd13,
        4'd6, 4'd15, 4'd0, 4'd9, 4'd10, 4'd4, 4'd5, 4'd3}},
    '{'{4'd12, 4'd1, 4'd10, 4'd15, 4'd9, 4'd2, 4'd6, 4'd8,
        4'd0, 4'd13, 4'd3, 4'd4, 4'd14, 4'd7, 4'd5, 4'd11},
      '{4'd10, 4'd15, 4'd4, 4'd2, 4'd7, 4'd12, 4'd9, 4'd5,
        4'd6, 4'd1, 4'd13, 4'd14, 4'd0, 4'd11, 4'd3, 4'd8},
      '{4'd9, 4'd14, 4'd15, 4'd5, 4'd2, 4'd8, 4'd12, 4'd3,
        4'd7, 4'd0, 4'd4, 4'd10, 4'd1, 4'd13, 4'd11, 4'd6},
      '{4'd4, 4'd3, 4'd2, 4'd12, 4'd9, 4'd5, 4'd15, 4'd10,
        4'd11, 4'd14, 4'd1, 4'd7, 4'd6, 4'd0, 4'd8, 4'd13}},
    '{'{4'd4, 4'd11, 4'd2, 4'd14, 4'd15, 4'd0, 4'd8, 4'd13,
        4'd3, 4'd12, 4'd9, 4'd7, 4'd5, 4'd10, 4'd6, 4'd1},
      '{4'd13, 4'd0, 4'd11, 4'd7, 4'd4, 4'd9, 4'd1, 4'd10,
        4'd14, 4'd3, 4'd5, 4'd12, 4'd2, 4'd15, 4'd8, 4'd6},
      '{4'd1, 4'd4, 4'd11, 4'd13, 4'd12, 4'd3, 4'd7, 4'd14,
        4'd10, 4'd15, 4'd6, 4'd8, 4'd0, 4'd5, 4'd9, 4'd2},
      '{4'd6, 4'd11, 4'd13, 4'd8, 4'd1, 4'd4, 4'd10, 4'd7,
        4'd9, 4'd5, 4'd0, 4'd15, 4'd14, 4'd2, 4'd3, 4'd12}},
    '{'{4'd13, 4'd2, 4'd8, 4'd4, 4'd6, 4'd15, 4'd11, 4'd1,
        4'd10, 4'd9, 4'd3, 4'd14, 4'd5, 4'd0, 4'd12, 4'd7},
      '{4'd1, 4'd15, 4'd13, 4'd8, 4'd10, 4'd3, 4'd7, 4'd4,
        4'd12, 4'd5, 4'd6, 4'd11, 4'd0, 4'd14, 4'd9, 4'd2},
      '{4'd7, 4'd11, 4'd4, 4'd1, 4'd9, 4'd12, 4'd14, 4'd2,
        4'd0, 4'd6, 4'd10, 4'd13, 4'd15, 4'd3, 4'd5, 4'd8},
      '{4'd2, 4'd1, 4'd14, 4'd7, 4'd4, 4'd10, 4'd8, 4'd13,
        4'd15, 4'd12, 4'd9, 4'd0, 4'd3, 4'd5, 4'd6, 4'd11}}};

  // Table entries count DES bits from 1 at the MSB.
  function automatic logic [63:0] ip_perm(logic [63:0] v);
    logic [63:0] res;
    logic [5:0]  idx;
    res = '0;
    for (int i = 0; i < 64; i++) begin
      idx = 6'(7'd64 - IP_TAB[i]);
      res[63-i] = v[idx];
    end
    return res;
  endfunction

  function automatic logic [63:0] fp_perm(logic [63:0] v);
    logic [63:0] res;
    logic [5:0]  idx;
    res = '0;
    for (int i = 0; i < 64; i++) begin
      idx = 6'(7'd64 - FP_TAB[i]);
      res[63-i] = v[idx];
    end
    return res;
  endfunction

  function automatic logic [47:0] exp_perm(logic [31:0] v);
    logic [47:0] res;
    logic [4:0]  idx;
    res = '0;
    for (int i = 0; i < 48; i++) begin
      idx = 5'(6'd32 - EXP_TAB[i]);
      res[47-i] = v[idx];
    end
    return res;
  endfunction

  function automatic logic [31:0] p_perm(logic [31:0] v);
    logic [31:0] res;
    logic [4:0]  idx;
    res = '0;
    for (int i = 0; i < 32; i++) begin
      idx = 5'(6'd32 - PERM_TAB[i]);
      res[31-i] = v[idx];
    end
    return res;
  endfunction

  function automatic logic [55:0] pc1_perm(logic [63:0] v);
    logic [55:0] res;
    logic [5:0]  idx;
    res = '0;
    for (int i = 0; i < 56; i++) begin
      idx = 6'(7'd64 - PC1_TAB[i]);
      res[55-i] = v[idx];
    end
    return res;
  endfunction

  function automatic logic [47:0] pc2_perm(logic [55:0] v);
    logic [47:0] res;
    logic [5:0]  idx;
    res = '0;
    for (int i = 0; i < 48; i++) begin
      idx = 6'(6'd56 - PC2_TAB[i]);
      res[47-i] = v[idx];
    end
    return res;
  endfunction

  // Total left rotation of both key halves after round r (0-based).
  function automatic int cum_shift(int r);
    int sum;
    sum = 0;
    for (int j = 0; j <= r; j++) begin
      sum += int'(ROT_TAB[j[3:0]]);
    end
    return sum;
  endfunction

  function automatic logic [27:0] rot28(logic [27:0] v, int s);
    return (v << s) | (v >> (KHALF_W - s));
  endfunction

  // Feistel function: expand, mix key, substitute, permute.
  function automatic logic [31:0] feistel(logic [31:0] r, logic [47:0] k);
    logic [47:0] e;
    logic [5:0]  six;
    logic [31:0] s_out;
    e = exp_perm(r) ^ k;
    s_out = '0;
    for (int b = 0; b < 8; b++) begin
      six = e[47-6*b -: 6];
      s_out[31-4*b -: 4] = SBOX_TAB[b][{six[5], six[0]}][six[4:1]];
    end
    return p_perm(s_out);
  endfunction

endpackage

// ===== hdl/des_key_sched.sv =====
// Key register and round-key schedule (PC-1, cumulative rotations, PC-2).
module des_key_sched #(
  parameter int ROUND_COUNT = des_pkg::ROUND_COUNT_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [des_pkg::BLOCK_W-1:0]            cfg_wdata,
  output logic [ROUND_COUNT-1:0][des_pkg::RKEY_W-1:0] round_keys
);
  import des_pkg::*;

  logic [BLOCK_W-1:0] cipher_key;
  logic [55:0]        cd;
  logic [27:0]        c0;
  logic [27:0]        d0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cipher_key <= '0;
    end else if (cfg_we) begin
      cipher_key <= cfg_wdata;
    end
  end

  assign cd = pc1_perm(cipher_key);
  assign c0 = cd[55:28];
  assign d0 = cd[27:0];

  // Each round key is a fixed bit selection of the key register.
  for (genvar i = 0; i < ROUND_COUNT; i++) begin : g_rk
    localparam int SH = cum_shift(i);
    assign round_keys[i] = pc2_perm({rot28(c0, SH), rot28(d0, SH)});
  end

endmodule

// ===== hdl/des_round.sv =====
// One Feistel round with its pipeline register.
module des_round (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  des_pkg::des_stage_t          in_stage,
  input  logic [des_pkg::RKEY_W-1:0]   key_enc,
  input  logic [des_pkg::RKEY_W-1:0]   key_dec,
  output logic                         out_valid,
  output des_pkg::des_stage_t          out_stage
);
  import des_pkg::*;

  rkey_t      key;
  des_stage_t stage_next;

  always_comb begin
    key = in_stage.mode ? key_dec : key_enc;
    stage_next.mode = in_stage.mode;
    stage_next.l    = in_stage.r;
    stage_next.r    = in_stage.l ^ feistel(in_stage.r, key);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_stage <= stage_next;
    end
  end

endmodule

// ===== hdl/des_obuf.sv =====
// Output register with a skid entry; parts pipeline stall from output ready.
module des_obuf (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  logic [des_pkg::BLOCK_W-1:0] push_data,
  output logic                        full,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [des_pkg::BLOCK_W-1:0] m_axis_tdata
);
  import des_pkg::*;

  logic               skid_valid;
  logic [BLOCK_W-1:0] skid_data;

  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      skid_valid    <= 1'b0;
    end else if (m_axis_tvalid && !m_axis_tready) begin
      if (push) begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      m_axis_tvalid <= 1'b1;
      skid_valid    <= 1'b0;
    end else begin
      m_axis_tvalid <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (m_axis_tvalid && !m_axis_tready) begin
      if (push) begin
        skid_data <= push_data;
      end
    end else if (skid_valid) begin
      m_axis_tdata <= skid_data;
    end else if (push) begin
      m_axis_tdata <= push_data;
    end
  end

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_axis_tvalid)
    else $error("skid entry held while output register empty");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> !push)
    else $error("push into full output buffer");

  a_drop_only_on_transfer: assert property (@(posedge clk) disable iff (rst)
    $fell(m_axis_tvalid) |-> $past(m_axis_tready))
    else $error("result dropped without transfer");

endmodule

// ===== hdl/des_block_cipher_core.sv =====
// DES ECB core: round-per-stage pipeline with key schedule and output skid buffer.
// Path: IP stage register, 16 round stage registers, then FP into the output register.
// Throughput: one block per cycle; set by the round-per-stage pipeline, every stage
// advances together whenever the output skid entry is free.
// Reset: key register clears to zero (round keys become the all-zero key schedule),
// all stage valid bits and the output buffer clear; no clearing pass is needed.
module des_block_cipher_core #(
  parameter int ROUND_COUNT = des_pkg::ROUND_COUNT_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // Key register write port
  input  logic                        cfg_we,
  input  logic [des_pkg::BLOCK_W-1:0] cfg_wdata,      // cipher_key
  // Input stream
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [des_pkg::BLOCK_W-1:0] s_axis_tdata,   // [63:0] data_in
  input  logic [0:0]                  s_axis_tuser,   // [0] mode: 0 encrypt, 1 decrypt
  // Result stream
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [des_pkg::BLOCK_W-1:0] m_axis_tdata    // [63:0] data_out
);
  import des_pkg::*;

  logic [ROUND_COUNT-1:0][RKEY_W-1:0] round_keys;

  // Stage 0 holds the block after IP; stage i+1 holds it after round i.
  logic       stg_valid [0:ROUND_COUNT];
  des_stage_t stg       [0:ROUND_COUNT];

  logic               en;
  logic               obuf_full;
  logic               push;
  logic [BLOCK_W-1:0] ip_out;
  logic [BLOCK_W-1:0] fp_out;

  // Advance the whole pipeline unless the skid entry is occupied; the skid
  // entry absorbs the one block that may leave the last stage during a stall.
  assign en            = !obuf_full;
  assign s_axis_tready = en;

  des_key_sched #(
    .ROUND_COUNT (ROUND_COUNT)
  ) u_key_sched (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .round_keys (round_keys)
  );

  // Initial permutation is pure wiring; register it with the mode bit.
  assign ip_out = ip_perm(s_axis_tdata);

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid[0] <= 1'b0;
    end else if (en) begin
      stg_valid[0] <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stg[0].mode <= s_axis_tuser[0];
      stg[0].l    <= ip_out[63:32];
      stg[0].r    <= ip_out[31:0];
    end
  end

  // Rounds: encrypt takes keys in order, decrypt takes them in reverse.
  for (genvar i = 0; i < ROUND_COUNT; i++) begin : g_round
    des_round u_round (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (stg_valid[i]),
      .in_stage  (stg[i]),
      .key_enc   (round_keys[i]),
      .key_dec   (round_keys[ROUND_COUNT-1-i]),
      .out_valid (stg_valid[i+1]),
      .out_stage (stg[i+1])
    );
  end

  // Final swap and inverse IP feed the output buffer.
  assign fp_out = fp_perm({stg[ROUND_COUNT].r, stg[ROUND_COUNT].l});
  assign push   = en && stg_valid[ROUND_COUNT];

  des_obuf u_obuf (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .push_data     (fp_out),
    .full          (obuf_full),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Every stage holds while stalled; the first and last stages are checked here.
  a_stall_holds_first: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(stg_valid[0]) && $stable(stg[0]))
    else $error("first stage moved during stall");

  a_stall_holds_last: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(stg_valid[ROUND_COUNT]) && $stable(stg[ROUND_COUNT]))
    else $error("last stage moved during stall");

  a_stage_advance: assert property (@(posedge clk) disable iff (rst)
    en && stg_valid[0] |=> stg_valid[1] && (stg[1].l == $past(stg[0].r)))
    else $error("round stage lost a block");

endmodule

// ===== tb/tb_des_block_cipher_core.sv =====
// Self-checking testbench for the DES ECB core: known-answer rows, then random traffic.
module tb_des_block_cipher_core;
  timeunit 1ns;
  timeprecision 1ps;

  import des_pkg::*;

  localparam logic MODE_ENC = 1'b0;
  localparam logic MODE_DEC = 1'b1;

  localparam int LIMIT_CYCLES   = 200000;
  localparam int RAND_PER_PHASE = 190;
  localparam int PHASE_COUNT    = 5;
  localparam int LONG_HOLD      = 200;  // receiver hold-off, long enough to back up the pipe
  localparam int KEY_SETTLE     = 4;    // quiet cycles before a key write
  localparam int TAIL_CYCLES    = 40;   // quiet time to watch for stray output after draining
  localparam int MAX_REPORTS    = 10;

  // Permutation maps, one byte per entry, first entry in the top byte.
  // Entries count bits from 1 at the MSB of the source value.
  localparam logic [511:0] IP_MAP = {
    8'd58, 8'd50, 8'd42, 8'd34, 8'd26, 8'd18, 8'd10, 8'd2,
    8'd60, 8'd52, 8'd44, 8'd36, 8'd28, 8'd20, 8'd12, 8'd4,
    8'd62, 8'd54, 8'd46, 8'd38, 8'd30, 8'd22, 8'd14, 8'd6,
    8'd64, 8'd56, 8'd48, 8'd40, 8'd32, 8'd24, 8'd16, 8'd8,
    8'd57, 8'd49, 8'd41, 8'd33, 8'd25, 8'd17, 8'd9,  8'd1,
    8'd59, 8'd51, 8'd43, 8'd35, 8'd27, 8'd19, 8'd11, 8'd3,
    8'd61, 8'd53, 8'd45, 8'd37, 8'd29, 8'd21, 8'd13, 8'd5,
    8'd63, 8'd55, 8'd47, 8'd39, 8'd31, 8'd23, 8'd15, 8'd7};

  localparam logic [255:0] P_MAP = {
    8'd16, 8'd7,  8'd20, 8'd21, 8'd29, 8'd12, 8'd28, 8'd17,
    8'd1,  8'd15, 8'd23, 8'd26, 8'd5,  8'd18, 8'd31, 8'd10,
    8'd2,  8'd8,  8'd24, 8'd14, 8'd32, 8'd27, 8'd3,  8'd9,
    8'd19, 8'd13, 8'd30, 8'd6,  8'd22, 8'd11, 8'd4,  8'd25};

  localparam logic [447:0] PC1_MAP = {
    8'd57, 8'd49, 8'd41, 8'd33, 8'd25, 8'd17, 8'd9,
    8'd1,  8'd58, 8'd50, 8'd42, 8'd34, 8'd26, 8'd18,
    8'd10, 8'd2,  8'd59, 8'd51, 8'd43, 8'd35, 8'd27,
    8'd19, 8'd11, 8'd3,  8'd60, 8'd52, 8'd44, 8'd36,
    8'd63, 8'd55, 8'd47, 8'd39, 8'd31, 8'd23, 8'd15,
    8'd7,  8'd62, 8'd54, 8'd46, 8'd38, 8'd30, 8'd22,
    8'd14, 8'd6,  8'd61, 8'd53, 8'd45, 8'd37, 8'd29,
    8'd21, 8'd13, 8'd5,  8'd28, 8'd20, 8'd12, 8'd4};

  localparam logic [383:0] PC2_MAP = {
    8'd14, 8'd17, 8'd11, 8'd24, 8'd1,  8'd5,
    8'd3,  8'd28, 8'd15, 8'd6,  8'd21, 8'd10,
    8'd23, 8'd19, 8'd12, 8'd4,  8'd26, 8'd8,
    8'd16, 8'd7,  8'd27, 8'd20, 8'd13, 8'd2,
    8'd41, 8'd52, 8'd31, 8'd37, 8'd47, 8'd55,
    8'd30, 8'd40, 8'd51, 8'd45, 8'd33, 8'd48,
    8'd44, 8'd49, 8'd39, 8'd56, 8'd34, 8'd53,
    8'd46, 8'd42, 8'd50, 8'd36, 8'd29, 8'd32};

  // S-boxes: 8 boxes x 4 rows, each row 16 nibbles, column 0 in the top nibble.
  localparam logic [2047:0] SBOX_BITS = {
    64'hE4D12FB83A6C5907, 64'h0F74E2D1A6CB9538, 64'h41E8D62BFC973A50, 64'hFC8249175B3EA06D,
    64'hF18E6B34972DC05A, 64'h3D47F28EC01A69B5, 64'h0E7BA4D158C6932F, 64'hD8A13F42B67C05E9,
    64'hA09E63F51DC7B428, 64'hD709346A285ECBF1, 64'hD6498F30B12C5AE7, 64'h1AD069874FE3B52C,
    64'h7DE3069A1285BC4F, 64'hD8B56F03472C1AE9, 64'hA690CB7DF13E5284, 64'h3F06A1D8945BC72E,
    64'h2C417AB6853FD0E9, 64'hEB2C47D150FA3986, 64'h421BAD78F9C5630E, 64'hB8C71E2D6F09A453,
    64'hC1AF92680D34E75B, 64'hAF427C9561DE0B38, 64'h9EF528C3704A1DB6, 64'h432C95FABE17608D,
    64'h4B2EF08D3C975A61, 64'hD0B7491AE35C2F86, 64'h14BDC37EAF680592, 64'h6BD814A7950FE23C,
    64'hD2846FB1A93E50C7, 64'h1FD8A374C56B0E92, 64'h7B419CE206ADF358, 64'h21E74A8DFC90356B};

  // One row of the directed table; answer is used only where pinned is set.
  typedef struct packed {
    logic               load_key;
    logic [63:0]        key;
    logic               mode;
    logic [63:0]        block;
    logic               pinned;
    logic [63:0]        answer;
  } vector_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [BLOCK_W-1:0] cfg_wdata = '0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [BLOCK_W-1:0] s_axis_tdata = '0;
  logic [0:0]         s_axis_tuser = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [BLOCK_W-1:0] m_axis_tdata;

  // Known answer travels beside the offered block so the monitor can pick it up.
  logic               pin_valid = 1'b0;
  logic [63:0]        pin_answer = '0;

  logic [47:0]        round_key_sched [16];
  logic [63:0]        expected_blocks [$];
  int                 fault_count = 0;
  int                 cycle_count = 0;
  int                 idle_pct = 0;
  int                 stall_pct = 0;
  int                 hold_left = 0;
  bit                 long_hold_req = 1'b0;

  des_block_cipher_core dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Gather n bits of a w-bit value in map order; result is right-aligned.
  function automatic logic [63:0] pick_bits(logic [63:0] v, int w, logic [511:0] map, int n);
    logic [63:0] res;
    int          src;
    res = '0;
    for (int i = 0; i < n; i++) begin
      src = int'(map[8*(n-1-i) +: 8]);
      res = {res[62:0], v[w - src]};
    end
    return res;
  endfunction

  // Expand a key into the sixteen round keys held by the predictor.
  function automatic void load_schedule(logic [63:0] key);
    logic [55:0] cd;
    logic [27:0] c;
    logic [27:0] d;
    logic [63:0] rk;
    int          shift;
    cd = 56'(pick_bits(key, 64, 512'(PC1_MAP), 56));
    c = cd[55:28];
    d = cd[27:0];
    for (int r = 0; r < 16; r++) begin
      // rounds 1, 2, 9 and 16 rotate by one, the others by two
      shift = (r == 0 || r == 1 || r == 8 || r == 15) ? 1 : 2;
      for (int j = 0; j < shift; j++) begin
        c = {c[26:0], c[27]};
        d = {d[26:0], d[27]};
      end
      rk = pick_bits({8'h00, c, d}, 56, 512'(PC2_MAP), 48);
      round_key_sched[r] = rk[47:0];
    end
  endfunction

  // Feistel function; the E expansion is built from its regular pattern.
  function automatic logic [31:0] feistel_mix(logic [31:0] r, logic [47:0] k);
    logic [47:0] e;
    logic [5:0]  six;
    logic [31:0] s_out;
    logic [63:0] p;
    int          n;
    int          k_idx;
    for (int b = 0; b < 8; b++) begin
      for (int j = 0; j < 6; j++) begin
        n = 4*b + j;
        if (n == 0) n = 32;
        if (n == 33) n = 1;
        e[47 - (6*b + j)] = r[32 - n];
      end
    end
    e = e ^ k;
    for (int b = 0; b < 8; b++) begin
      six = e[47-6*b -: 6];
      k_idx = 64*b + 32*int'(six[5]) + 16*int'(six[0]) + int'(six[4:1]);
      s_out[31-4*b -: 4] = SBOX_BITS[4*(511-k_idx) +: 4];
    end
    p = pick_bits({32'h0, s_out}, 32, 512'(P_MAP), 32);
    return p[31:0];
  endfunction

  // Full block transform; the final permutation is taken as the inverse of IP.
  function automatic logic [63:0] des_crypt_block(logic mode, logic [63:0] din);
    logic [63:0] t;
    logic [31:0] l;
    logic [31:0] r;
    logic [31:0] nr;
    logic [47:0] rk;
    logic [63:0] pre;
    logic [63:0] res;
    int          dst;
    t = pick_bits(din, 64, IP_MAP, 64);
    l = t[63:32];
    r = t[31:0];
    for (int i = 0; i < 16; i++) begin
      rk = (mode == MODE_DEC) ? round_key_sched[15-i] : round_key_sched[i];
      nr = l ^ feistel_mix(r, rk);
      l = r;
      r = nr;
    end
    pre = {r, l};
    res = '0;
    for (int i = 0; i < 64; i++) begin
      dst = int'(IP_MAP[8*(63-i) +: 8]);
      res[64 - dst] = pre[63-i];
    end
    return res;
  endfunction

  // Check the result stream first, then record the expectation for an input transfer.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_blocks.size() == 0) begin
          fault_count++;
          if (fault_count <= MAX_REPORTS)
            $display("unexpected result %h at cycle %0d", m_axis_tdata, cycle_count);
        end else begin
          if (m_axis_tdata !== expected_blocks[0]) begin
            fault_count++;
            if (fault_count <= MAX_REPORTS)
              $display("data_out mismatch at cycle %0d: expected %h got %h",
                       cycle_count, expected_blocks[0], m_axis_tdata);
          end
          void'(expected_blocks.pop_front());
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (pin_valid)
          expected_blocks.push_back(pin_answer);
        else
          expected_blocks.push_back(des_crypt_block(s_axis_tuser[0], s_axis_tdata));
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off counted here.
  always @(negedge clk) begin
    if (long_hold_req) begin
      long_hold_req = 1'b0;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog: end the run if traffic never drains.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Offer one block; hold it until the transfer, idling before it at random.
  task automatic offer_block(input logic mode, input logic [63:0] blk,
                             input logic pinned, input logic [63:0] answer);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= blk;
    pin_valid     <= pinned;
    pin_answer    <= answer;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Drain the core, then write the key and rebuild the predicted schedule.
  task automatic load_key(input logic [63:0] key);
    s_axis_tvalid <= 1'b0;
    while (expected_blocks.size() != 0) @(negedge clk);
    repeat (KEY_SETTLE) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= key;
    @(negedge clk);
    cfg_we <= 1'b0;
    load_schedule(key);
  endtask

  initial begin : stimulus
    vector_t     dir_rows [$];
    vector_t     row;
    logic [63:0] blk;
    logic [63:0] phase_key;
    logic        m;

    // Predictor starts from the schedule of the all-zero key, as the core does.
    load_schedule(64'h0);

    // Known answers: zero and all-ones keys, the classic textbook key, and keys
    // that differ only in parity bits, which must give the same ciphertext.
    dir_rows.push_back('{1'b0, 64'h0, MODE_ENC, 64'h0, 1'b1, 64'h8CA64DE9C1B123A7});
    dir_rows.push_back('{1'b0, 64'h0, MODE_DEC, 64'h8CA64DE9C1B123A7, 1'b1, 64'h0});
    dir_rows.push_back('{1'b0, 64'h0, MODE_ENC, 64'hFFFFFFFFFFFFFFFF, 1'b0, 64'h0});
    dir_rows.push_back('{1'b0, 64'h0, MODE_DEC, 64'hFFFFFFFFFFFFFFFF, 1'b0, 64'h0});
    dir_rows.push_back('{1'b1, 64'h0101010101010101, MODE_ENC, 64'h0, 1'b1,
                         64'h8CA64DE9C1B123A7});
    dir_rows.push_back('{1'b0, 64'h0, MODE_DEC, 64'h8CA64DE9C1B123A7, 1'b1, 64'h0});
    dir_rows.push_back('{1'b1, 64'hFEFEFEFEFEFEFEFE, MODE_ENC, 64'hFFFFFFFFFFFFFFFF, 1'b1,
                         64'h7359B2163E4EDC58});
    dir_rows.push_back('{1'b1, 64'hFFFFFFFFFFFFFFFF, MODE_ENC, 64'hFFFFFFFFFFFFFFFF, 1'b1,
                         64'h7359B2163E4EDC58});
    dir_rows.push_back('{1'b0, 64'h0, MODE_DEC, 64'h7359B2163E4EDC58, 1'b1,
                         64'hFFFFFFFFFFFFFFFF});
    dir_rows.push_back('{1'b0, 64'h0, MODE_ENC, 64'h0, 1'b0, 64'h0});
    dir_rows.push_back('{1'b1, 64'h133457799BBCDFF1, MODE_ENC, 64'h0123456789ABCDEF, 1'b1,
                         64'h85E813540F0AB405});
    dir_rows.push_back('{1'b0, 64'h0, MODE_DEC, 64'h85E813540F0AB405, 1'b1,
                         64'h0123456789ABCDEF});
    dir_rows.push_back('{1'b1, 64'h123556789ABDDEF0, MODE_ENC, 64'h0123456789ABCDEF, 1'b1,
                         64'h85E813540F0AB405});
    dir_rows.push_back('{1'b0, 64'h0, MODE_ENC, 64'h5555555555555555, 1'b0, 64'h0});
    dir_rows.push_back('{1'b0, 64'h0, MODE_DEC, 64'hAAAAAAAAAAAAAAAA, 1'b0, 64'h0});
    dir_rows.push_back('{1'b0, 64'h0, MODE_ENC, 64'h8000000000000000, 1'b0, 64'h0});
    dir_rows.push_back('{1'b0, 64'h0, MODE_DEC, 64'h0000000000000001, 1'b0, 64'h0});
    dir_rows.push_back('{1'b1, 64'h0, MODE_ENC, 64'h0123456789ABCDEF, 1'b0, 64'h0});

    // Hold reset, then release it on a falling edge.
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed rows, back to back; key changes drain the core first.
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.load_key) load_key(row.key);
      offer_block(row.mode, row.block, row.pinned, row.answer);
    end

    // Random traffic in phases that vary the idling on each side and the key.
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  phase_key = {$urandom, $urandom}; end
        1: begin idle_pct = 61; stall_pct = 0;  phase_key = 64'h0; end
        2: begin idle_pct = 0;  stall_pct = 61; phase_key = 64'hFFFFFFFFFFFFFFFF; end
        3: begin idle_pct = 35; stall_pct = 35; phase_key = {$urandom, $urandom}; end
        default: begin idle_pct = 0; stall_pct = 0; phase_key = {$urandom, $urandom}; end
      endcase
      load_key(phase_key);
      // Back up the pipe once: receiver holds off while blocks keep coming.
      if (ph == 0) long_hold_req = 1'b1;
      repeat (RAND_PER_PHASE) begin
        m = 1'($urandom_range(1));
        blk = {$urandom, $urandom};
        case ($urandom_range(15))
          0: blk = 64'h0;
          1: blk = 64'hFFFFFFFFFFFFFFFF;
          default: ;
        endcase
        offer_block(m, blk, 1'b0, 64'h0);
      end
    end

    // Drop valid, wait for the last result, then watch for stray output.
    s_axis_tvalid <= 1'b0;
    while (expected_blocks.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fault_count == 0 && expected_blocks.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
